@@ src/sqvs_pkg.sv @@
`timescale 1ns / 1ps
package sqvs_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int X0_W       = 44;

  localparam logic [2:0] REG_SCALE    = 3'd0;
  localparam logic [2:0] REG_CAMERA_X = 3'd1;
  localparam logic [2:0] REG_CAMERA_Y = 3'd2;
  localparam logic [2:0] REG_FOLLOW_X = 3'd3;
  localparam logic [2:0] REG_FOLLOW_Y = 3'd4;

  localparam logic [14:0] QUARTER_ONE = 15'd16384;
  localparam logic [12:0] SIN_C = 13'd4640;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [16:0] SIN_A = 17'd102944;

  typedef struct packed {
    logic signed [23:0] rect_x;
    logic signed [23:0] rect_y;
    logic [22:0]        rect_w;
    logic [22:0]        rect_h;
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic [ANGLE_BITS-1:0] angle;
    logic [15:0]        uv_offset_u;
    logic [15:0]        uv_offset_v;
    logic [15:0]        uv_size_u;
    logic [15:0]        uv_size_v;
    logic [31:0]        color;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [1:0]         corner;
    logic               last_corner;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        scale;
    logic signed [23:0] camera_x;
    logic signed [23:0] camera_y;
    logic               follow_x;
    logic               follow_y;
  } cfg_t;

  typedef struct packed {
    logic signed [32:0]     sx;
    logic signed [32:0]     sy;
    logic [30:0]            sw;
    logic [30:0]            sh;
    logic signed [15:0]     ax;
    logic signed [15:0]     ay;
    logic signed [X0_W-1:0] x0;
    logic signed [X0_W-1:0] y0;
    logic                   rot;
    logic signed [15:0]     sin_v;
    logic signed [15:0]     cos_v;
    logic [15:0]            uo;
    logic [15:0]            vo;
    logic [15:0]            us;
    logic [15:0]            vs;
    logic [31:0]            color;
  } qent_t;

  function automatic logic [15:0] angle_phase(input logic [ANGLE_BITS-1:0] ang);
    logic [ANGLE_BITS+15:0] wide;
    wide = {ang, 16'd0};
    return wide[ANGLE_BITS+15 -: 16];
  endfunction

endpackage

@@ src/sqvs_front.sv @@
`timescale 1ns / 1ps
module sqvs_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sqvs_pkg::in_item_t in_data,
  input  sqvs_pkg::cfg_t    cfg,
  output logic              push,
  output sqvs_pkg::qent_t   push_data,
  input  logic              q_full
);
  import sqvs_pkg::*;

  localparam int CSH = 14 + FRAC_BITS;
  localparam logic signed [49:0] CEIL_ADD = 50'((64'd1 << CSH) - 64'd1);

  logic fe;
  logic [6:0] v;

  in_item_t it0, it1, it2, it3, it4, it5;
  logic signed [23:0] camx0, camy0;
  logic [15:0] sc0;

  logic signed [32:0] sx1, sy1, sx2, sy2, sx3, sy3, sx4, sy4, sx5, sy5;
  logic [30:0] sw1, sh1, sw2, sh2, sw3, sh3, sw4, sh4, sw5, sh5;
  logic [14:0] zs1, zc1, zs2, zc2, zs3, zc3, zs4, zc4, zs5, zc5;
  logic ns1, nc1, ns2, nc2, ns3, nc3, ns4, nc4, ns5, nc5;
  logic [14:0] z2s2, z2c2, z2s3, z2c3;
  logic signed [47:0] axsw2, aysh2;
  logic [12:0] t1s3, t1c3;
  logic signed [X0_W-1:0] x03, y03, x04, y04, x05, y05;
  logic [15:0] t2s4, t2c4;
  logic [15:0] ys5, yc5;
  qent_t q6;

  assign fe = !v[6] || !q_full;
  assign in_stall = !fe;
  assign push = v[6] && !q_full;
  assign push_data = q6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (fe) begin
      v <= {v[5:0], in_valid};
    end
  end

  // stage 0: capture
  always_ff @(posedge clk) begin
    if (fe) begin
      it0 <= in_data;
      sc0 <= cfg.scale;
      camx0 <= cfg.follow_x ? cfg.camera_x : 24'sd0;
      camy0 <= cfg.follow_y ? cfg.camera_y : 24'sd0;
    end
  end

  // stage 1: scaling and quadrant split
  logic signed [40:0] px1, py1;
  logic [38:0] pw1, ph1;
  logic [15:0] ph_s, ph_c;
  always_comb begin
    px1 = it0.rect_x * $signed({1'b0, sc0});
    py1 = it0.rect_y * $signed({1'b0, sc0});
    pw1 = it0.rect_w * sc0;
    ph1 = it0.rect_h * sc0;
    ph_s = angle_phase(it0.angle);
    ph_c = ph_s + 16'd16384;
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      it1 <= it0;
      sx1 <= px1[40:8] + 33'(camx0);
      sy1 <= py1[40:8] + 33'(camy0);
      sw1 <= pw1[38:8];
      sh1 <= ph1[38:8];
      zs1 <= ph_s[14] ? QUARTER_ONE - {1'b0, ph_s[13:0]} : {1'b0, ph_s[13:0]};
      zc1 <= ph_c[14] ? QUARTER_ONE - {1'b0, ph_c[13:0]} : {1'b0, ph_c[13:0]};
      ns1 <= ph_s[15];
      nc1 <= ph_c[15];
    end
  end

  // stage 2: z squared, anchor times size
  logic [29:0] zzs, zzc;
  always_comb begin
    zzs = zs1 * zs1;
    zzc = zc1 * zc1;
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      it2 <= it1;
      sx2 <= sx1; sy2 <= sy1; sw2 <= sw1; sh2 <= sh1;
      zs2 <= zs1; zc2 <= zc1; ns2 <= ns1; nc2 <= nc1;
      z2s2 <= zzs[28:14];
      z2c2 <= zzc[28:14];
      axsw2 <= it1.anchor_x * $signed({1'b0, sw1});
      aysh2 <= it1.anchor_y * $signed({1'b0, sh1});
    end
  end

  // stage 3: first polynomial term, unrotated corner rounded up
  logic [27:0] cs3, cc3;
  logic signed [49:0] vx3, vy3, qx3, qy3;
  always_comb begin
    cs3 = SIN_C * z2s2;
    cc3 = SIN_C * z2c2;
    vx3 = (50'(sx2) <<< 14) - 50'(axsw2) + CEIL_ADD;
    vy3 = (50'(sy2) <<< 14) - 50'(aysh2) + CEIL_ADD;
    qx3 = (vx3 >>> CSH) <<< FRAC_BITS;
    qy3 = (vy3 >>> CSH) <<< FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      it3 <= it2;
      sx3 <= sx2; sy3 <= sy2; sw3 <= sw2; sh3 <= sh2;
      zs3 <= zs2; zc3 <= zc2; ns3 <= ns2; nc3 <= nc2;
      z2s3 <= z2s2; z2c3 <= z2c2;
      t1s3 <= cs3[26:14];
      t1c3 <= cc3[26:14];
      x03 <= X0_W'(qx3);
      y03 <= X0_W'(qy3);
    end
  end

  // stage 4: second term
  logic [15:0] tbs, tbc;
  logic [30:0] ms4, mc4;
  always_comb begin
    tbs = SIN_B - 16'(t1s3);
    tbc = SIN_B - 16'(t1c3);
    ms4 = tbs * z2s3;
    mc4 = tbc * z2c3;
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      it4 <= it3;
      sx4 <= sx3; sy4 <= sy3; sw4 <= sw3; sh4 <= sh3;
      zs4 <= zs3; zc4 <= zc3; ns4 <= ns3; nc4 <= nc3;
      x04 <= x03; y04 <= y03;
      t2s4 <= ms4[29:14];
      t2c4 <= mc4[29:14];
    end
  end

  // stage 5: outer term
  logic [16:0] tas, tac;
  logic [31:0] ms5, mc5;
  always_comb begin
    tas = SIN_A - 17'(t2s4);
    tac = SIN_A - 17'(t2c4);
    ms5 = tas * zs4;
    mc5 = tac * zc4;
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      it5 <= it4;
      sx5 <= sx4; sy5 <= sy4; sw5 <= sw4; sh5 <= sh4;
      ns5 <= ns4; nc5 <= nc4;
      x05 <= x04; y05 <= y04;
      ys5 <= ms5[31:16];
      yc5 <= mc5[31:16];
      zs5 <= zs4; zc5 <= zc4;
    end
  end

  // stage 6: clamp and sign, hand over to the queue
  logic [15:0] cls, clc;
  always_comb begin
    cls = (ys5 > 16'(QUARTER_ONE)) ? 16'(QUARTER_ONE) : ys5;
    clc = (yc5 > 16'(QUARTER_ONE)) ? 16'(QUARTER_ONE) : yc5;
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      q6.sx <= sx5; q6.sy <= sy5;
      q6.sw <= sw5; q6.sh <= sh5;
      q6.ax <= it5.anchor_x; q6.ay <= it5.anchor_y;
      q6.x0 <= x05; q6.y0 <= y05;
      q6.rot <= (it5.angle != '0) && ((zs5 | zc5) != '0);
      q6.sin_v <= ns5 ? -$signed(cls) : $signed(cls);
      q6.cos_v <= nc5 ? -$signed(clc) : $signed(clc);
      q6.uo <= it5.uv_offset_u; q6.vo <= it5.uv_offset_v;
      q6.us <= it5.uv_size_u; q6.vs <= it5.uv_size_v;
      q6.color <= it5.color;
    end
  end

endmodule

@@ src/sqvs_queue.sv @@
`timescale 1ns / 1ps
module sqvs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sqvs_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sqvs_pkg::qent_t head
);
  import sqvs_pkg::*;

  qent_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign not_empty = cnt != 2'd0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/sqvs_back.sv @@
`timescale 1ns / 1ps
module sqvs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  sqvs_pkg::qent_t   head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output sqvs_pkg::out_item_t out_data
);
  import sqvs_pkg::*;

  logic be;
  logic [1:0] k;
  logic v1, v2, v3;

  assign be = !out_valid || !out_stall;
  assign pop = be && not_empty && (k == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 2'd0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; out_valid <= 1'b0;
    end else if (be) begin
      if (not_empty) k <= k + 2'd1;
      v1 <= not_empty;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // stage 1: corner offsets times sine and cosine
  logic signed [16:0] u, w;
  always_comb begin
    u = -17'(head.ax) + (k[0] ? 17'sd16384 : 17'sd0);
    w = -17'(head.ay) + (k[1] ? 17'sd16384 : 17'sd0);
  end

  qent_t e1, e2;
  logic [1:0] k1, k2, k3;
  logic [16:0] tu1, tv1, tu2, tv2, tu3, tv3;
  logic signed [31:0] uc1, ws1, us1, wc1;
  always_ff @(posedge clk) begin
    if (be) begin
      e1 <= head;
      k1 <= k;
      uc1 <= 32'(u * head.cos_v);
      ws1 <= 32'(w * head.sin_v);
      us1 <= 32'(u * head.sin_v);
      wc1 <= 32'(w * head.cos_v);
      tu1 <= 17'(head.uo) + (k[0] ? 17'(head.us) : 17'd0);
      tv1 <= 17'(head.vo) + (k[1] ? 17'(head.vs) : 17'd0);
    end
  end

  // stage 2: times the scaled size
  logic signed [63:0] pa2, pb2, pc2, pd2;
  always_ff @(posedge clk) begin
    if (be) begin
      e2 <= e1; k2 <= k1; tu2 <= tu1; tv2 <= tv1;
      pa2 <= uc1 * $signed({1'b0, e1.sw});
      pb2 <= ws1 * $signed({1'b0, e1.sh});
      pc2 <= us1 * $signed({1'b0, e1.sw});
      pd2 <= wc1 * $signed({1'b0, e1.sh});
    end
  end

  // stage 3: round, add position, pick the unrotated form when angle is zero
  logic signed [63:0] ox, oy;
  logic signed [45:0] rx, ry, nx, ny;
  logic signed [45:0] px3, py3;
  always_comb begin
    ox = pa2 - pb2 + 64'sd134217728;
    oy = pc2 + pd2 + 64'sd134217728;
    rx = 46'(e2.sx) + 46'(ox >>> 28);
    ry = 46'(e2.sy) + 46'(oy >>> 28);
    nx = 46'(e2.x0) + (k2[0] ? 46'($signed({1'b0, e2.sw})) : 46'sd0);
    ny = 46'(e2.y0) + (k2[1] ? 46'($signed({1'b0, e2.sh})) : 46'sd0);
  end

  logic [31:0] col3;
  always_ff @(posedge clk) begin
    if (be) begin
      k3 <= k2; tu3 <= tu2; tv3 <= tv2; col3 <= e2.color;
      px3 <= e2.rot ? rx : nx;
      py3 <= e2.rot ? ry : ny;
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [45:0] a);
    if (a > 46'sd2147483647) return 32'sh7fffffff;
    if (a < -46'sd2147483648) return 32'sh80000000;
    return 32'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (be) begin
      out_data.vertex_x <= sat32(px3);
      out_data.vertex_y <= sat32(py3);
      out_data.tex_u <= tu3;
      out_data.tex_v <= tv3;
      out_data.vertex_color <= col3;
      out_data.corner <= k3;
      out_data.last_corner <= k3 == 2'd3;
    end
  end

endmodule

@@ src/sprite_quad_vertex_setup.sv @@
`timescale 1ns / 1ps
// Sprite quad vertex setup: each transferred sprite instance yields four corner vertices
// (top-left, top-right, bottom-left, bottom-right), one per cycle while the queue holds an
// instance and out_stall is low; the back end pops an instance from the queue as it issues
// that instance's last corner, so its corner output sets the instance rate. A seven-stage
// front end does scaling, the sine/cosine polynomial and the unrotated corner, a two-entry
// queue decouples it from a four-stage back end that rotates each corner and saturates.
// Configuration writes must be made while the block is idle.
module sprite_quad_vertex_setup #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sqvs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sqvs_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import sqvs_pkg::*;

  cfg_t cfg;
  qent_t push_data, head;
  logic push, full, pop, not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale <= 16'd256;
      cfg.camera_x <= '0;
      cfg.camera_y <= '0;
      cfg.follow_x <= 1'b0;
      cfg.follow_y <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCALE:    cfg.scale <= cfg_data[15:0];
        REG_CAMERA_X: cfg.camera_x <= cfg_data;
        REG_CAMERA_Y: cfg.camera_y <= cfg_data;
        REG_FOLLOW_X: cfg.follow_x <= cfg_data[0];
        REG_FOLLOW_Y: cfg.follow_y <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sqvs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .cfg,
    .push, .push_data, .q_full(full)
  );

  sqvs_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .not_empty, .head
  );

  sqvs_back u_back (
    .clk, .rst, .not_empty, .head, .pop, .out_valid, .out_stall, .out_data
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import sqvs_pkg::*;

  localparam int FRAC = 8;
  localparam int LIMIT = 400000;
  localparam int N_RANDOM = 260;

  class vertex_board;
    logic [15:0] scale;
    logic signed [23:0] cam_x;
    logic signed [23:0] cam_y;
    logic fol_x;
    logic fol_y;
    out_item_t pending[$];
    int errors;
    int vertices;

    function void reset_regs();
      scale = 16'd256;
      cam_x = '0;
      cam_y = '0;
      fol_x = 1'b0;
      fol_y = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_SCALE: scale = val[15:0];
        REG_CAMERA_X: cam_x = val;
        REG_CAMERA_Y: cam_y = val;
        REG_FOLLOW_X: fol_x = val[0];
        REG_FOLLOW_Y: fol_y = val[0];
        default: ;
      endcase
    endfunction

    // floor division by 2^k for signed values
    function longint fshift(longint v, int k);
      return v >>> k;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint qsin(longint z);
      longint z2, t, y;
      z2 = (z * z) >>> 14;
      t = (4640 * z2) >>> 14;
      t = 42047 - t;
      t = (t * z2) >>> 14;
      t = 102944 - t;
      y = (t * z) >>> 16;
      if (y > 16384) y = 16384;
      return y;
    endfunction

    function longint turn_sin(logic [15:0] p);
      longint v;
      longint r;
      r = longint'(p[13:0]);
      v = p[14] ? qsin(16384 - r) : qsin(r);
      return p[15] ? -v : v;
    endfunction

    function void note_sprite(in_item_t it);
      longint sc, sx, sy, sw, sh, ax, ay, x0, y0, s, c, u, v, ox, oy;
      longint px, py;
      logic [15:0] ph;
      out_item_t o;
      sc = longint'(scale);
      sx = fshift(longint'(it.rect_x) * sc, 8);
      sy = fshift(longint'(it.rect_y) * sc, 8);
      sw = (longint'(it.rect_w) * sc) >>> 8;
      sh = (longint'(it.rect_h) * sc) >>> 8;
      ax = longint'(it.anchor_x);
      ay = longint'(it.anchor_y);
      if (fol_x) sx += longint'(cam_x);
      if (fol_y) sy += longint'(cam_y);
      ph = it.angle;
      s = turn_sin(ph);
      c = turn_sin(ph + 16'd16384);
      x0 = -fshift(-(sx * 16384 - ax * sw), 14 + FRAC) * (64'sd1 << FRAC);
      y0 = -fshift(-(sy * 16384 - ay * sh), 14 + FRAC) * (64'sd1 << FRAC);
      for (int k = 0; k < 4; k++) begin
        if (it.angle == 0) begin
          px = x0 + ((k & 1) ? sw : 0);
          py = y0 + ((k & 2) ? sh : 0);
        end else begin
          u = -ax + ((k & 1) ? 16384 : 0);
          v = -ay + ((k & 2) ? 16384 : 0);
          ox = (u * sw) * c - (v * sh) * s;
          oy = (u * sw) * s + (v * sh) * c;
          px = sx + fshift(ox + (64'sd1 << 27), 28);
          py = sy + fshift(oy + (64'sd1 << 27), 28);
        end
        o.vertex_x = 32'(sat(px));
        o.vertex_y = 32'(sat(py));
        o.tex_u = {1'b0, it.uv_offset_u} + ((k & 1) ? {1'b0, it.uv_size_u} : 17'd0);
        o.tex_v = {1'b0, it.uv_offset_v} + ((k & 2) ? {1'b0, it.uv_size_v} : 17'd0);
        o.vertex_color = it.color;
        o.corner = 2'(k);
        o.last_corner = (k == 3);
        pending.push_back(o);
      end
    endfunction

    function void check_vertex(out_item_t got);
      out_item_t exp_v;
      vertices++;
      if (pending.size() == 0) begin
        $display("%0t: vertex with nothing pending: %p", $time, got);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got.vertex_x !== exp_v.vertex_x) begin
        $display("%0t: vertex_x exp %0d got %0d", $time, exp_v.vertex_x, got.vertex_x);
        errors++;
      end
      if (got.vertex_y !== exp_v.vertex_y) begin
        $display("%0t: vertex_y exp %0d got %0d", $time, exp_v.vertex_y, got.vertex_y);
        errors++;
      end
      if (got.tex_u !== exp_v.tex_u) begin
        $display("%0t: tex_u exp %0h got %0h", $time, exp_v.tex_u, got.tex_u);
        errors++;
      end
      if (got.tex_v !== exp_v.tex_v) begin
        $display("%0t: tex_v exp %0h got %0h", $time, exp_v.tex_v, got.tex_v);
        errors++;
      end
      if (got.vertex_color !== exp_v.vertex_color) begin
        $display("%0t: color exp %0h got %0h", $time, exp_v.vertex_color, got.vertex_color);
        errors++;
      end
      if (got.corner !== exp_v.corner) begin
        $display("%0t: corner exp %0d got %0d", $time, exp_v.corner, got.corner);
        errors++;
      end
      if (got.last_corner !== exp_v.last_corner) begin
        $display("%0t: last_corner exp %0b got %0b", $time, exp_v.last_corner,
                 got.last_corner);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  vertex_board board;
  int cycles = 0;
  int sprites_sent = 0;
  bit stall_enable = 1'b1;

  always #1 clk = ~clk;

  sprite_quad_vertex_setup dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check on transfer, then draw a new stall pattern
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_vertex(out_data);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (stall_enable && $urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 5);
      end
    end
  end

  // valid stays up across back-to-back transfers and drops only for a gap
  task automatic send_sprite(in_item_t it);
    int gap;
    gap = stall_enable ? $urandom_range(0, 5) : 0;
    if ($urandom_range(0, 2) == 0) gap = 0;
    cfg_write <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sprite(it);
    sprites_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write enable is dropped by the next sprite transfer
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  function automatic in_item_t rand_sprite();
    in_item_t it;
    it.rect_x = 24'($urandom);
    it.rect_y = 24'($urandom);
    it.rect_w = 23'($urandom);
    it.rect_h = 23'($urandom);
    if ($urandom_range(0, 1)) begin
      it.rect_x = 24'($signed($urandom_range(0, 8191)) - 4096);
      it.rect_y = 24'($signed($urandom_range(0, 8191)) - 4096);
      it.rect_w = 23'($urandom_range(0, 16383));
      it.rect_h = 23'($urandom_range(0, 16383));
    end
    it.anchor_x = 16'($urandom);
    it.anchor_y = 16'($urandom);
    if ($urandom_range(0, 1)) begin
      it.anchor_x = 16'($urandom_range(0, 16384));
      it.anchor_y = 16'($urandom_range(0, 16384));
    end
    case ($urandom_range(0, 5))
      0: it.angle = 16'd0;
      1: it.angle = {2'($urandom_range(0, 3)), 14'd0};
      default: it.angle = 16'($urandom);
    endcase
    it.uv_offset_u = 16'($urandom_range(0, 32768));
    it.uv_offset_v = 16'($urandom_range(0, 32768));
    it.uv_size_u = 16'($urandom_range(0, 32768));
    it.uv_size_v = 16'($urandom_range(0, 32768));
    if ($urandom_range(0, 7) == 0) begin
      it.uv_offset_u = 16'($urandom);
      it.uv_offset_v = 16'($urandom);
      it.uv_size_u = 16'($urandom);
      it.uv_size_v = 16'($urandom);
    end
    it.color = $urandom;
    return it;
  endfunction

  initial begin
    in_item_t it;
    board = new();
    board.reset_regs();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, zero and quarter-turn angles, saturation
    it = '0;
    send_sprite(it);
    it.rect_x = 24'sh7FFFFF; it.rect_y = 24'sh800000;
    it.rect_w = 23'h7FFFFF; it.rect_h = 23'h7FFFFF;
    it.anchor_x = 16'sh7FFF; it.anchor_y = 16'sh8000;
    it.uv_offset_u = 16'hFFFF; it.uv_offset_v = 16'hFFFF;
    it.uv_size_u = 16'hFFFF; it.uv_size_v = 16'hFFFF;
    it.color = 32'hFFFFFFFF;
    send_sprite(it);
    for (int a = 0; a < 8; a++) begin
      it.angle = 16'(a * 8192);
      send_sprite(it);
    end
    it.angle = 16'hFFFF;
    send_sprite(it);
    it.angle = 16'd1;
    send_sprite(it);
    it = '0;
    it.rect_x = -24'sd301; it.rect_y = 24'sd77; it.rect_w = 23'd1000;
    it.rect_h = 23'd555; it.anchor_x = 16'sd8192; it.anchor_y = 16'sd8192;
    it.uv_size_u = 16'd32768; it.uv_size_v = 16'd32768;
    it.uv_offset_u = 16'd32768; it.uv_offset_v = 16'd32768;
    send_sprite(it);
    it.angle = 16'd12345;
    send_sprite(it);
    drain();

    // register settings, extremes included; index out of range too
    write_reg(3'd7, 24'hFFFFFF);
    write_reg(REG_SCALE, 24'h00FFFF);
    write_reg(REG_CAMERA_X, 24'h7FFFFF);
    write_reg(REG_CAMERA_Y, 24'h800000);
    write_reg(REG_FOLLOW_X, 24'd1);
    write_reg(REG_FOLLOW_Y, 24'd1);
    for (int i = 0; i < 70; i++) send_sprite(rand_sprite());
    drain();
    write_reg(REG_SCALE, 24'd0);
    write_reg(REG_FOLLOW_Y, 24'd0);
    write_reg(REG_CAMERA_X, 24'h800000);
    for (int i = 0; i < 30; i++) send_sprite(rand_sprite());
    drain();
    write_reg(REG_SCALE, 24'd384);
    write_reg(REG_CAMERA_X, 24'h000123);
    write_reg(REG_CAMERA_Y, 24'hFFF000);
    write_reg(REG_FOLLOW_X, 24'd0);
    write_reg(REG_FOLLOW_Y, 24'd1);
    for (int i = 0; i < 80; i++) begin
      stall_enable = (i < 20 || i >= 40);
      send_sprite(rand_sprite());
    end
    drain();
    write_reg(REG_SCALE, 24'd256);
    write_reg(REG_FOLLOW_X, 24'd1);
    write_reg(REG_CAMERA_X, 24'hFFFFFF);
    for (int i = 0; i < N_RANDOM - 180; i++) send_sprite(rand_sprite());
    drain();

    $display("sent %0d sprites, checked %0d vertices over four register settings",
             sprites_sent, board.vertices);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ sprite_quad_vertex_setup.f @@
src/sqvs_pkg.sv
src/sqvs_front.sv
src/sqvs_queue.sv
src/sqvs_back.sv
src/sprite_quad_vertex_setup.sv
test/tb_top.sv
